>>> design/mpfw_pkg.sv
// ----------------------------------------------------------------------------
// mpfw_pkg
// shared types and constants of the page organized frame buffer writer
// ----------------------------------------------------------------------------
package mpfw_pkg;

  localparam int unsigned ColumnsDef = 128;
  localparam int unsigned PagesDef   = 8;

  // apb register map, byte address = 4 * index
  localparam int unsigned ApbAw = 5;
  localparam int unsigned ApbDw = 32;

  localparam logic [2:0] RegPortrait = 3'd0;
  localparam logic [2:0] RegXStart   = 3'd1;
  localparam logic [2:0] RegXEnd     = 3'd2;
  localparam logic [2:0] RegYStart   = 3'd3;
  localparam logic [2:0] RegYEnd     = 3'd4;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       portrait;
    logic [6:0] x_start;
    logic [6:0] x_end;
    logic [6:0] y_start;
    logic [6:0] y_end;
  } cfg_t;

  // cursor reload request with the start values it loads
  typedef struct packed {
    logic       valid;
    logic [6:0] x;
    logic [6:0] y;
  } reload_t;

  // classified item travelling from front to back
  typedef struct packed {
    logic       on_screen;
    logic [3:0] page;
    logic [6:0] col;
    logic [2:0] bit_sel;
    logic       black;
  } entry_t;

endpackage

>>> design/mpfw_pix_if.sv
// ----------------------------------------------------------------------------
// mpfw_pix_if
// input item channel: one pixel update
// ----------------------------------------------------------------------------
interface mpfw_pix_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [6:0] point_x;
  logic [6:0] point_y;
  logic       pixel_black;

  modport source (output valid, output op, output point_x, output point_y,
                  output pixel_black, input ready);
  modport sink (input valid, input op, input point_x, input point_y,
                input pixel_black, output ready);
endinterface

>>> design/mpfw_res_if.sv
// ----------------------------------------------------------------------------
// mpfw_res_if
// result item channel: one touched frame buffer byte
// ----------------------------------------------------------------------------
interface mpfw_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] page_index;
  logic [6:0] column_index;
  logic [7:0] column_byte;
  logic       written;

  modport source (output valid, output page_index, output column_index,
                  output column_byte, output written, input ready);
  modport sink (input valid, input page_index, input column_index,
                input column_byte, input written, output ready);
endinterface

>>> design/mono_page_framebuffer_writer_unit.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_writer_unit
// one-bit page organized frame buffer with point and window stream updates
// ----------------------------------------------------------------------------
// items pass the queue, the store read stage and the result register in turn
// throughput: one item per cycle while the result channel takes results,
// set by the single write port of the store
// the back end forwards the last written byte, so repeated hits do not stall
// reset: control and cfg registers clear at once, then a clearing pass zeroes
// 2**(page bits + column bits) bytes (1024 by default) with input ready low
module mono_page_framebuffer_writer_unit
  import mpfw_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned PAGES   = PagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ApbAw-1:0]   paddr,
  input  logic [ApbDw-1:0]   pwdata,
  output logic [ApbDw-1:0]   prdata,
  output logic               pready,
  // item channels
  mpfw_pix_if.sink           pix_i,
  mpfw_res_if.source         res_o
);

  cfg_t       cfg_q, cfg_d;
  reload_t    reload;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  // front to queue
  logic       push;
  entry_t     push_entry;
  logic       q_full;

  // queue to back
  logic       q_valid;
  logic       pop;
  entry_t     q_entry;

  logic       clearing;
  logic       back_busy;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register write decode, writes beyond the map are dropped
  always_comb begin
    cfg_d        = cfg_q;
    reload.valid = 1'b0;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegPortrait: cfg_d.portrait = pwdata[0];
        RegXStart: begin
          cfg_d.x_start = pwdata[6:0];
          reload.valid  = 1'b1;
        end
        RegXEnd: cfg_d.x_end = pwdata[6:0];
        RegYStart: begin
          cfg_d.y_start = pwdata[6:0];
          reload.valid  = 1'b1;
        end
        RegYEnd: cfg_d.y_end = pwdata[6:0];
        default: cfg_d = cfg_q;
      endcase
    end
    // either start write reloads the cursor from both new start values
    reload.x = cfg_d.x_start;
    reload.y = cfg_d.y_start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.portrait <= 1'b0;
      cfg_q.x_start  <= 7'd0;
      cfg_q.x_end    <= 7'd127;
      cfg_q.y_start  <= 7'd0;
      cfg_q.y_end    <= 7'd63;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      RegPortrait: prdata = ApbDw'(cfg_q.portrait);
      RegXStart:   prdata = ApbDw'(cfg_q.x_start);
      RegXEnd:     prdata = ApbDw'(cfg_q.x_end);
      RegYStart:   prdata = ApbDw'(cfg_q.y_start);
      RegYEnd:     prdata = ApbDw'(cfg_q.y_end);
      default:     prdata = '0;
    endcase
  end

  // front: accept, cursor, orientation mapping
  mpfw_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .reload_i (reload),
    .hold_i   (clearing),
    .q_full_i (q_full),
    .pix      (pix_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // decoupling queue
  mpfw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // back: store read-modify-write and result register
  mpfw_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .pop_o      (pop),
    .clearing_o (clearing),
    .busy_o     (back_busy),
    .res        (res_o)
  );

`ifndef SYNTHESIS
  a_hold_while_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !pix_i.ready)
    else $error("item accepted during clearing pass");
  a_idle_after_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing) |-> !q_valid && !back_busy)
    else $error("work in flight when clearing pass ended");
  a_offscreen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.written) |->
      (res_o.page_index == 3'd0 && res_o.column_index == 7'd0 &&
       res_o.column_byte == 8'd0))
    else $error("off-screen result carries nonzero fields");
`endif

endmodule

>>> design/mpfw_front.sv
// ----------------------------------------------------------------------------
// mpfw_front
// accepts items, keeps the stream cursor and maps pixels to page and column
// ----------------------------------------------------------------------------
module mpfw_front
  import mpfw_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned PAGES   = PagesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  reload_t         reload_i,
  input  logic            hold_i,
  input  logic            q_full_i,
  mpfw_pix_if.sink        pix,
  output logic            push_o,
  output entry_t          entry_o
);

  localparam logic [8:0] Rows    = 9'(PAGES * 8);
  localparam logic [8:0] Cols    = 9'(COLUMNS);
  localparam logic [6:0] RowLast = 7'(PAGES * 8 - 1);

  logic [6:0] cur_x_q, cur_x_d;
  logic [6:0] cur_y_q, cur_y_d;
  logic [6:0] px, py;
  logic [6:0] row;
  logic [8:0] lim_x, lim_y;
  logic [7:0] nx, ny;
  logic       on_screen;

  assign pix.ready = !q_full_i && !hold_i;
  assign push_o    = pix.valid && pix.ready;

  assign px = pix.op ? cur_x_q : pix.point_x;
  assign py = pix.op ? cur_y_q : pix.point_y;

  assign lim_x     = cfg_i.portrait ? Rows : Cols;
  assign lim_y     = cfg_i.portrait ? Cols : Rows;
  assign on_screen = ({2'b00, px} < lim_x) && ({2'b00, py} < lim_y);

  // portrait turns the logical x axis upside down onto panel rows
  assign row = cfg_i.portrait ? (RowLast - px) : py;

  always_comb begin
    entry_o.on_screen = on_screen;
    entry_o.page      = row[6:3];
    entry_o.col       = cfg_i.portrait ? py : px;
    entry_o.bit_sel   = row[2:0];
    entry_o.black     = pix.pixel_black;
  end

  // cursor steps along x, wraps to the next row, then back to the window top
  assign nx = {1'b0, cur_x_q} + 8'd1;
  assign ny = {1'b0, cur_y_q} + 8'd1;

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    if (reload_i.valid) begin
      cur_x_d = reload_i.x;
      cur_y_d = reload_i.y;
    end else if (push_o && pix.op) begin
      if (nx > {1'b0, cfg_i.x_end}) begin
        cur_x_d = cfg_i.x_start;
        cur_y_d = (ny > {1'b0, cfg_i.y_end}) ? cfg_i.y_start : ny[6:0];
      end else begin
        cur_x_d = nx[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

endmodule

>>> design/mpfw_queue.sv
// ----------------------------------------------------------------------------
// mpfw_queue
// short queue decoupling the front from the back
// ----------------------------------------------------------------------------
module mpfw_queue
  import mpfw_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue pushed while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");
  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

>>> design/mpfw_back.sv
// ----------------------------------------------------------------------------
// mpfw_back
// frame store, clearing pass and read-modify-write with forwarding
// ----------------------------------------------------------------------------
module mpfw_back
  import mpfw_pkg::*;
#(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned PAGES   = PagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  entry_t      q_entry_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        busy_o,
  mpfw_res_if.source  res
);

  localparam int unsigned PageW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned AddrW = PageW + ColW;
  localparam int unsigned Depth = 1 << AddrW;

  logic [7:0]       mem [Depth];
  logic [7:0]       rd_q;

  logic             clr_q;
  logic [AddrW-1:0] clr_cnt_q;

  logic             s1_vld_q;
  entry_t           s1_q;
  logic [AddrW-1:0] s1_addr;
  logic [AddrW-1:0] q_addr;

  logic             lw_vld_q;
  logic [AddrW-1:0] lw_addr_q;
  logic [7:0]       lw_byte_q;

  logic             res_vld_q;
  logic [2:0]       res_page_q;
  logic [6:0]       res_col_q;
  logic [7:0]       res_byte_q;
  logic             res_wr_q;

  logic             adv;
  logic             wr_en;
  logic [7:0]       old_byte, new_byte, mask;

  assign q_addr  = {PageW'(q_entry_i.page), ColW'(q_entry_i.col)};
  assign s1_addr = {PageW'(s1_q.page), ColW'(s1_q.col)};

  assign adv   = s1_vld_q && (!res_vld_q || res.ready);
  assign pop_o = q_valid_i && (!s1_vld_q || adv) && !clr_q;
  assign wr_en = adv && s1_q.on_screen;

  // the write that left stage one last edge is not in rd_q yet
  assign old_byte = (lw_vld_q && lw_addr_q == s1_addr) ? lw_byte_q : rd_q;
  assign mask     = 8'(1) << s1_q.bit_sel;
  assign new_byte = s1_q.black ? (old_byte | mask) : (old_byte & ~mask);

  assign clearing_o = clr_q;
  assign busy_o     = s1_vld_q || res_vld_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem[s1_addr] <= new_byte;
    end
    if (pop_o) begin
      rd_q <= mem[q_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= q_entry_i;
    end
    if (wr_en) begin
      lw_addr_q <= s1_addr;
      lw_byte_q <= new_byte;
    end
    if (adv) begin
      res_page_q <= s1_q.on_screen ? s1_q.page[2:0] : '0;
      res_col_q  <= s1_q.on_screen ? s1_q.col : '0;
      res_byte_q <= s1_q.on_screen ? new_byte : '0;
      res_wr_q   <= s1_q.on_screen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      lw_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == '1) begin
          clr_q <= 1'b0;
        end
      end
      if (clr_q) begin
        lw_vld_q <= 1'b0;
      end else if (wr_en) begin
        lw_vld_q <= 1'b1;
      end
      if (pop_o) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (res.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  assign res.valid        = res_vld_q;
  assign res.page_index   = res_page_q;
  assign res.column_index = res_col_q;
  assign res.column_byte  = res_byte_q;
  assign res.written      = res_wr_q;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the page organized frame buffer writer: a shadow
// frame store and window cursor predict every touched byte, the apb port
// sweeps orientation and window settings, both channels idle at random
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mpfw_pkg::*;

  // op field encoding of the pixel channel
  localparam logic OpPoint  = 1'b0;
  localparam logic OpStream = 1'b1;

  localparam int unsigned FrameBytes = PagesDef * ColumnsDef;
  localparam int unsigned PanelRows  = PagesDef * 8;

  // one touched byte as the result channel reports it
  typedef struct packed {
    logic [2:0] page;
    logic [6:0] col;
    logic [7:0] col_byte;
    logic       written;
  } touched_byte_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  mpfw_pix_if pix ();
  mpfw_res_if res ();

  mono_page_framebuffer_writer_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix),
    .res_o   (res)
  );

  // shadow of the block: frame store, window registers and stream cursor
  logic [7:0]    shadow_frame [FrameBytes];
  cfg_t          shadow_cfg;
  logic [6:0]    cur_x;
  logic [6:0]    cur_y;
  touched_byte_t pending_bytes [$];

  // run statistics
  int unsigned items_sent;
  int unsigned stream_sent;
  int unsigned off_screen_sent;
  int unsigned results_seen;
  int unsigned reg_writes;
  int unsigned errors;

  // idling knobs: idle_on for the sender and the receiver, hold_request for the receiver
  bit idle_on;
  int unsigned hold_request;

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // step the window cursor along x, wrapping to the next row and then back
  // to the window start; increments are compared before any 7-bit wrap
  function automatic void advance_stream_cursor();
    int unsigned nx;
    int unsigned ny;
    nx = int'(cur_x) + 1;
    if (nx > shadow_cfg.x_end) begin
      cur_x = shadow_cfg.x_start;
      ny = int'(cur_y) + 1;
      if (ny > shadow_cfg.y_end) cur_y = shadow_cfg.y_start;
      else cur_y = 7'(ny);
    end else begin
      cur_x = 7'(nx);
    end
  endfunction

  // apply one pixel item to the shadow store and return the touched byte
  function automatic touched_byte_t model_pixel_update(input logic op,
                                                       input logic [6:0] px,
                                                       input logic [6:0] py,
                                                       input logic black);
    logic [6:0]    ux;
    logic [6:0]    uy;
    int unsigned   lw;
    int unsigned   lh;
    int unsigned   col;
    int unsigned   row;
    int unsigned   idx;
    logic [7:0]    mask;
    touched_byte_t r;
    r = '0;
    if (op == OpStream) begin
      // position comes from the cursor, which moves even for off-screen pixels
      ux = cur_x;
      uy = cur_y;
      advance_stream_cursor();
    end else begin
      ux = px;
      uy = py;
    end
    lw = shadow_cfg.portrait ? PanelRows : ColumnsDef;
    lh = shadow_cfg.portrait ? ColumnsDef : PanelRows;
    // off-screen pixels leave the store alone and report all zeros
    if (ux < lw && uy < lh) begin
      if (shadow_cfg.portrait) begin
        col = 32'(uy);
        row = lw - 1 - 32'(ux);
      end else begin
        col = 32'(ux);
        row = 32'(uy);
      end
      idx  = (row / 8) * ColumnsDef + col;
      mask = 8'h01 << (row % 8);
      if (black) shadow_frame[idx] = shadow_frame[idx] | mask;
      else shadow_frame[idx] = shadow_frame[idx] & ~mask;
      r.page     = 3'(row / 8);
      r.col      = 7'(col);
      r.col_byte = shadow_frame[idx];
      r.written  = 1'b1;
    end
    return r;
  endfunction

  // register write as seen by the shadow; a start write reloads the cursor
  function automatic void model_reg_write(input logic [2:0] idx, input logic [6:0] value);
    case (idx)
      RegPortrait: shadow_cfg.portrait = value[0];
      RegXStart: begin
        shadow_cfg.x_start = value;
        cur_x = shadow_cfg.x_start;
        cur_y = shadow_cfg.y_start;
      end
      RegXEnd: shadow_cfg.x_end = value;
      RegYStart: begin
        shadow_cfg.y_start = value;
        cur_x = shadow_cfg.x_start;
        cur_y = shadow_cfg.y_start;
      end
      RegYEnd: shadow_cfg.y_end = value;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking: every accepted result against the oldest predicted byte
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    touched_byte_t want;
    if (rst_ni && res.valid && res.ready) begin
      results_seen++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %0h/%0h/%0h/%0b",
                 $time, res.page_index, res.column_index, res.column_byte, res.written);
      end else begin
        want = pending_bytes.pop_front();
        check_field("page_index", 8'(want.page), 8'(res.page_index));
        check_field("column_index", 8'(want.col), 8'(res.column_index));
        check_field("column_byte", want.col_byte, res.column_byte);
        check_field("written", 8'(want.written), 8'(res.written));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_receiver
    int unsigned hold_cnt;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        // long stall counted here, so the block fills and stops taking items
        hold_cnt = hold_request;
        hold_request = 0;
        res.ready <= 1'b0;
        repeat (hold_cnt) @(posedge clk_i);
        res.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side and register access
  // ---------------------------------------------------------------------------

  // offer one item until accepted; valid stays high when the next item follows
  task automatic send_pixel(input logic op, input logic [6:0] px, input logic [6:0] py,
                            input logic black);
    touched_byte_t r;
    pix.valid       <= 1'b1;
    pix.op          <= op;
    pix.point_x     <= px;
    pix.point_y     <= py;
    pix.pixel_black <= black;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    r = model_pixel_update(op, px, py, black);
    pending_bytes.push_back(r);
    items_sent++;
    if (op == OpStream) stream_sent++;
    if (!r.written) off_screen_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every predicted byte has come back
  task automatic drain_results();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // idle point for register writes: results drained and the pipeline left empty
  task automatic settle();
    drain_results();
    repeat (4) @(posedge clk_i);
  endtask

  // apb write with setup and access phases, then read back the register
  task automatic reg_write(input logic [2:0] idx, input logic [6:0] value);
    logic [ApbDw-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ApbDw'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    model_reg_write(idx, value);
    reg_writes++;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    want = (idx == RegPortrait) ? ApbDw'(value[0]) : ApbDw'(value);
    if (prdata !== want) begin
      errors++;
      $display("%0t: readback of register %0d, expected %0h, actual %0h",
               $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // all five registers; the end values first so the start writes load the cursor
  task automatic program_window(input logic portrait, input logic [6:0] xs,
                                input logic [6:0] xe, input logic [6:0] ys,
                                input logic [6:0] ye);
    settle();
    reg_write(RegPortrait, {6'd0, portrait});
    reg_write(RegXEnd, xe);
    reg_write(RegYEnd, ye);
    reg_write(RegXStart, xs);
    reg_write(RegYStart, ys);
  endtask

  // random mix of point and stream items, a quarter aimed at a few hot bytes
  task automatic random_pixels(input int unsigned count);
    logic       op;
    logic [6:0] px;
    logic [6:0] py;
    logic       black;
    for (int unsigned i = 0; i < count; i++) begin
      // now and then the sender waits out the whole pipeline
      if ($urandom_range(0, 79) == 0) drain_results();
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        px = 7'($urandom_range(0, 3));
        py = 7'($urandom_range(0, 15));
      end else begin
        px = 7'($urandom_range(0, 127));
        py = 7'($urandom_range(0, 127));
      end
      black = 1'($urandom_range(0, 1));
      send_pixel(op, px, py, black);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // landscape corners, same-byte hits back to back, clearing, off-screen rows
  task automatic test_point_extremes();
    send_pixel(OpPoint, 7'd0, 7'd0, 1'b1);
    send_pixel(OpPoint, 7'd127, 7'd63, 1'b1);
    send_pixel(OpPoint, 7'd127, 7'd0, 1'b1);
    send_pixel(OpPoint, 7'd0, 7'd63, 1'b1);
    // column 0 page 0 again, exercises forwarding of the last written byte
    send_pixel(OpPoint, 7'd0, 7'd1, 1'b1);
    send_pixel(OpPoint, 7'd0, 7'd7, 1'b1);
    send_pixel(OpPoint, 7'd0, 7'd1, 1'b0);
    // below the panel in landscape
    send_pixel(OpPoint, 7'd5, 7'd64, 1'b1);
    send_pixel(OpPoint, 7'd127, 7'd127, 1'b1);
  endtask

  // small window at the bottom right corner wraps row then back to start,
  // then an inverted window steps once and reloads
  task automatic test_stream_window();
    program_window(1'b0, 7'd125, 7'd127, 7'd62, 7'd63);
    repeat (7) send_pixel(OpStream, 7'($urandom), 7'($urandom), 1'b1);
    program_window(1'b0, 7'd10, 7'd3, 7'd5, 7'd2);
    repeat (2) send_pixel(OpStream, 7'($urandom), 7'($urandom), 1'b1);
  endtask

  // portrait mapping: column is y, row is 63 - x, x beyond 63 is off screen
  task automatic test_portrait();
    program_window(1'b1, 7'd62, 7'd63, 7'd127, 7'd127);
    send_pixel(OpPoint, 7'd0, 7'd0, 1'b1);
    send_pixel(OpPoint, 7'd63, 7'd127, 1'b1);
    send_pixel(OpPoint, 7'd64, 7'd5, 1'b1);
    send_pixel(OpPoint, 7'd63, 7'd0, 1'b1);
    repeat (3) send_pixel(OpStream, 7'($urandom), 7'($urandom), 1'b1);
  endtask

  // receiver holds off while the sender keeps going, input must stall
  task automatic test_backpressure();
    settle();
    idle_on = 1'b0;
    hold_request = 60;
    random_pixels(32);
    idle_on = 1'b1;
  endtask

  // a series of window settings, extremes first, then random ones
  task automatic test_random_windows();
    program_window(1'b0, 7'd0, 7'd127, 7'd0, 7'd63);
    random_pixels(110);
    program_window(1'b1, 7'd0, 7'd63, 7'd0, 7'd127);
    random_pixels(110);
    // single pixel window
    program_window(1'b0, 7'd40, 7'd40, 7'd10, 7'd10);
    random_pixels(100);
    // fully inverted window at the register extremes
    program_window(1'b1, 7'd127, 7'd0, 7'd127, 7'd0);
    random_pixels(100);
    // window running off the bottom of the landscape panel
    program_window(1'b0, 7'd120, 7'd127, 7'd56, 7'd127);
    random_pixels(110);
    program_window(1'b0, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    random_pixels(110);
    program_window(1'b1, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    random_pixels(110);
  endtask

  // last part of the run at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    program_window(1'($urandom), 7'($urandom_range(0, 20)), 7'($urandom_range(100, 127)),
                   7'($urandom_range(0, 20)), 7'($urandom_range(40, 127)));
    random_pixels(80);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix.valid       = 1'b0;
    pix.op          = OpPoint;
    pix.point_x     = '0;
    pix.point_y     = '0;
    pix.pixel_black = 1'b0;
    idle_on         = 1'b1;
    hold_request    = 0;
    // shadow reset state
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    shadow_cfg = '{portrait: 1'b0, x_start: 7'd0, x_end: 7'd127,
                   y_start: 7'd0, y_end: 7'd63};
    cur_x = '0;
    cur_y = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing pass holds input ready low, the first send waits it out
    test_point_extremes();
    test_stream_window();
    test_portrait();
    test_backpressure();
    test_random_windows();
    test_full_rate();
    drain_results();
    repeat (10) @(posedge clk_i);
    $display("covered %0d pixel items (%0d streamed, %0d off screen), %0d register writes",
             items_sent, stream_sent, off_screen_sent, reg_writes);
    $display("%0d result items compared, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
